// ===== rtl/qmls_pkg.sv =====
// Shared widths, operation codes and reply status codes of the queued mutex lock server.
`timescale 1ns / 1ps

package qmls_pkg;

  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 6;
  localparam int RANK_W   = 8;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  // Largest number of mutexes and link entries the request fields can reach.
  localparam int INDEX_SPAN = 1 << INDEX_W;
  localparam int RANK_SPAN  = 1 << RANK_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOCK    = 2'd0,
    MODE_TRYLOCK = 2'd1,
    MODE_UNLOCK  = 2'd2,
    MODE_INVALID = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_OWNER = 2'd1,
    STATUS_BAD_REQ   = 2'd2
  } status_t;

  // Per-mutex record kept in the slot memory.
  typedef struct packed {
    logic [RANK_W-1:0] owner;
    logic [RANK_W-1:0] head;
    logic [RANK_W-1:0] tail;
  } slot_rec_t;

endpackage

// ===== rtl/queued_mutex_lock_server.sv =====
// Top level of the queued mutex lock server: request control, flags and reply register.
// Replies are registered: out_tvalid is loaded from the read stage, or from the link stage
// when an unlock hands the mutex to a waiter that still has others queued behind it.
// A new request is taken only once the last one has retired, as the read-modify-write of
// the slot memory and the dependent read of the link memory must finish first.
// A reply that is not taken holds the next request that needs a reply in its commit cycle.
// Reset (rst_n, synchronous): all mutexes free with no waiters, mutex limit = 64.
`timescale 1ns / 1ps

module queued_mutex_lock_server #(
  parameter int MUTEX_SLOTS = 64,
  parameter int RANKS       = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] mutex_index, [13:6] requester_rank, [15:14] zero
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // Reply channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] dest_rank
  output logic [2:0]  out_tuser,  // [0] granted, [2:1] status
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // [6:0] mutex_limit
);

  localparam int SD = (MUTEX_SLOTS < qmls_pkg::INDEX_SPAN) ? MUTEX_SLOTS
                                                            : qmls_pkg::INDEX_SPAN;
  localparam int SW = (SD > 1) ? $clog2(SD) : 1;
  localparam int LD = (RANKS < qmls_pkg::RANK_SPAN) ? RANKS : qmls_pkg::RANK_SPAN;
  localparam int LW = (LD > 1) ? $clog2(LD) : 1;
  localparam int RW = qmls_pkg::RANK_W;
  localparam int SLOT_REC_W = $bits(qmls_pkg::slot_rec_t);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_LINK = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [qmls_pkg::COUNT_W-1:0]    count_r;
  qmls_pkg::mode_t                 mode_r;
  logic [RW-1:0]                   rank_r;
  logic [SW-1:0]                   addr_r;
  logic                            bad_r;
  logic [SD-1:0]                   held_r, held_nxt;
  logic [SD-1:0]                   busy_r, busy_nxt;   // wait list not empty
  logic                            out_valid_r;
  logic [RW-1:0]                   out_dest_r;
  logic                            out_grant_r;
  qmls_pkg::status_t               out_status_r;

  // Link slot of a rank: rank modulo the link table depth, as a constant table.
  logic [LW-1:0] link_tbl [qmls_pkg::RANK_SPAN];
  for (genvar g = 0; g < qmls_pkg::RANK_SPAN; g++) begin : g_link_tbl
    assign link_tbl[g] = LW'(g % LD);
  end

  logic                            in_acc;
  qmls_pkg::mode_t                 in_mode;
  logic [qmls_pkg::INDEX_W-1:0]    in_index;
  logic [RW-1:0]                   in_rank;
  logic                            in_bad;

  qmls_pkg::slot_rec_t             slot_rd, slot_wr;
  logic [SLOT_REC_W-1:0]           slot_rdata;
  logic                            slot_we;
  logic [RW-1:0]                   link_rdata, link_wdata;
  logic                            link_we, link_re;
  logic [LW-1:0]                   link_waddr, link_raddr;

  logic                            held_q, busy_q, out_ok;
  logic                            need_reply, commit;
  logic [RW-1:0]                   rep_dest;
  logic                            rep_grant;
  qmls_pkg::status_t               rep_status;

  assign in_mode  = qmls_pkg::mode_t'(in_tuser);
  assign in_index = in_tdata[5:0];
  assign in_rank  = in_tdata[13:6];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign in_bad = (in_mode == qmls_pkg::MODE_INVALID)
               || ({1'b0, in_index} >= count_r)
               || (32'(in_index) >= 32'(MUTEX_SLOTS));

  qmls_ram #(.W(SLOT_REC_W), .D(SD)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (addr_r),
    .wdata (slot_wr),
    .re    (in_acc),
    .raddr (SW'(in_index)),
    .rdata (slot_rdata)
  );

  qmls_ram #(.W(RW), .D(LD)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  assign slot_rd = qmls_pkg::slot_rec_t'(slot_rdata);
  assign held_q  = held_r[addr_r];
  assign busy_q  = busy_r[addr_r];
  assign out_ok  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    busy_nxt   = busy_r;
    slot_wr    = slot_rd;
    slot_we    = 1'b0;
    link_we    = 1'b0;
    link_waddr = link_tbl[slot_rd.tail];
    link_wdata = rank_r;
    link_re    = 1'b0;
    link_raddr = link_tbl[slot_rd.head];
    need_reply = 1'b0;
    commit     = 1'b0;
    rep_dest   = rank_r;
    rep_grant  = 1'b0;
    rep_status = qmls_pkg::STATUS_OK;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (bad_r) begin
          need_reply = 1'b1;
          rep_status = qmls_pkg::STATUS_BAD_REQ;
        end else begin
          case (mode_r)
            qmls_pkg::MODE_LOCK, qmls_pkg::MODE_TRYLOCK: begin
              if (!held_q) begin
                need_reply       = 1'b1;
                rep_grant        = 1'b1;
                held_nxt[addr_r] = 1'b1;
                slot_wr.owner    = rank_r;
                slot_we          = 1'b1;
              end else if (mode_r == qmls_pkg::MODE_TRYLOCK) begin
                need_reply = 1'b1;
              end else if (busy_q) begin
                // Append behind the current tail.
                link_we      = 1'b1;
                slot_wr.tail = rank_r;
                slot_we      = 1'b1;
              end else begin
                busy_nxt[addr_r] = 1'b1;
                slot_wr.head     = rank_r;
                slot_wr.tail     = rank_r;
                slot_we          = 1'b1;
              end
            end
            qmls_pkg::MODE_UNLOCK: begin
              if (!held_q || (slot_rd.owner != rank_r)) begin
                need_reply = 1'b1;
                rep_status = qmls_pkg::STATUS_NOT_OWNER;
              end else if (!busy_q) begin
                held_nxt[addr_r] = 1'b0;
              end else if (slot_rd.head == slot_rd.tail) begin
                need_reply       = 1'b1;
                rep_dest         = slot_rd.head;
                rep_grant        = 1'b1;
                busy_nxt[addr_r] = 1'b0;
                slot_wr.owner    = slot_rd.head;
                slot_we          = 1'b1;
              end else begin
                // The new head comes from the link memory in the next cycle.
                link_re = 1'b1;
              end
            end
            default: begin
              need_reply = 1'b1;
              rep_status = qmls_pkg::STATUS_BAD_REQ;
            end
          endcase
        end

        if (link_re) begin
          state_nxt = S_LINK;
        end else if (!need_reply || out_ok) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LINK: begin
        need_reply    = 1'b1;
        rep_dest      = slot_rd.head;
        rep_grant     = 1'b1;
        slot_wr.owner = slot_rd.head;
        slot_wr.head  = link_rdata;
        slot_we       = 1'b1;
        if (out_ok) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Nothing is written until the request can retire.
    if (!commit) begin
      held_nxt = held_r;
      busy_nxt = busy_r;
      slot_we  = 1'b0;
      link_we  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= qmls_pkg::COUNT_RESET;
      held_r      <= '0;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      busy_r  <= busy_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
      if (commit && need_reply) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_mode;
      rank_r <= in_rank;
      addr_r <= SW'(in_index);
      bad_r  <= in_bad;
    end
    if (commit && need_reply) begin
      out_dest_r   <= rep_dest;
      out_grant_r  <= rep_grant;
      out_status_r <= rep_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_dest_r;
  assign out_tuser  = {out_status_r, out_grant_r};

  // A mutex with waiters is always held.
  a_wait_implies_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD && !bad_r && busy_q) |-> held_q)
    else $error("wait list present on a free mutex");

  // A grant is never paired with an error status.
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tuser[2:1] == qmls_pkg::STATUS_OK))
    else $error("granted reply carries an error status");

  // Every accepted request moves on to the slot read.
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_RD))
    else $error("accepted request did not reach the read stage");

  // The link stage is only entered from the read stage.
  a_link_from_rd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_LINK) |-> ($past(state_r) == S_RD))
    else $error("link stage entered out of order");

endmodule

// ===== rtl/qmls_ram.sv =====
// Simple dual-port synchronous memory with one write port and a registered read port.
`timescale 1ns / 1ps

module qmls_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                    wdata,
  input  logic                            re,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                    rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sim/queued_mutex_lock_server_test.sv =====
// Self-checking testbench for the queued mutex lock server with a lock-table scoreboard.
`timescale 1ns / 1ps

module queued_mutex_lock_server_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 10;

  typedef logic [qmls_pkg::INDEX_W-1:0] index_t;
  typedef logic [qmls_pkg::RANK_W-1:0]  rank_t;
  typedef logic [qmls_pkg::COUNT_W-1:0] count_t;

  typedef struct {
    rank_t             dest;
    logic              granted;
    qmls_pkg::status_t status;
  } reply_t;

  // Mirror of the lock tables; predicts the reply, if any, of every accepted request.
  class lock_table_board;
    bit                held[qmls_pkg::INDEX_SPAN];
    rank_t             owner[qmls_pkg::INDEX_SPAN];
    bit                waiting[qmls_pkg::INDEX_SPAN];
    rank_t             head[qmls_pkg::INDEX_SPAN];
    rank_t             tail[qmls_pkg::INDEX_SPAN];
    rank_t             next_link[qmls_pkg::RANK_SPAN];
    count_t            count;
    reply_t            pending[$];
    int                errors;

    function new();
      count = qmls_pkg::COUNT_RESET;
      errors = 0;
      for (int i = 0; i < qmls_pkg::INDEX_SPAN; i++) begin
        held[i] = 0;
        waiting[i] = 0;
      end
    endfunction

    function void push_reply(rank_t dest, logic granted, qmls_pkg::status_t status);
      reply_t r;
      r.dest = dest;
      r.granted = granted;
      r.status = status;
      pending.push_back(r);
    endfunction

    function void note_request(qmls_pkg::mode_t mode, index_t idx, rank_t rank);
      rank_t heir;
      if (mode == qmls_pkg::MODE_INVALID || {1'b0, idx} >= count) begin
        push_reply(rank, 1'b0, qmls_pkg::STATUS_BAD_REQ);
      end else if (mode == qmls_pkg::MODE_LOCK) begin
        if (!held[idx]) begin
          held[idx] = 1;
          owner[idx] = rank;
          push_reply(rank, 1'b1, qmls_pkg::STATUS_OK);
        end else if (waiting[idx]) begin
          // Link entries are per rank, so a rank queued on two mutexes relinks.
          next_link[tail[idx]] = rank;
          tail[idx] = rank;
        end else begin
          waiting[idx] = 1;
          head[idx] = rank;
          tail[idx] = rank;
        end
      end else if (mode == qmls_pkg::MODE_TRYLOCK) begin
        if (!held[idx]) begin
          held[idx] = 1;
          owner[idx] = rank;
          push_reply(rank, 1'b1, qmls_pkg::STATUS_OK);
        end else begin
          push_reply(rank, 1'b0, qmls_pkg::STATUS_OK);
        end
      end else begin
        if (!held[idx] || owner[idx] != rank) begin
          push_reply(rank, 1'b0, qmls_pkg::STATUS_NOT_OWNER);
        end else if (waiting[idx]) begin
          heir = head[idx];
          if (head[idx] == tail[idx]) waiting[idx] = 0;
          else head[idx] = next_link[heir];
          owner[idx] = heir;
          push_reply(heir, 1'b1, qmls_pkg::STATUS_OK);
        end else begin
          held[idx] = 0;
        end
      end
    endfunction

    function void check_reply(rank_t dest, logic granted,
                              logic [qmls_pkg::STATUS_W-1:0] status);
      reply_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected reply dest_rank %0d granted %0d status %0d",
                 $time, dest, granted, status);
        errors++;
      end else begin
        want = pending.pop_front();
        if (dest !== want.dest) begin
          $display("%0t: dest_rank expected %0d actual %0d", $time, want.dest, dest);
          errors++;
        end
        if (granted !== want.granted) begin
          $display("%0t: granted expected %0d actual %0d", $time, want.granted, granted);
          errors++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;

  lock_table_board board;
  bit quiet;
  bit no_gaps;
  bit hold_replies;
  int cycles;

  queued_mutex_lock_server u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("queued_mutex_lock_server_test NOT OK");
      $finish;
    end
  end

  // Reply beats are sampled mid-cycle, where every signal is settled for the coming edge.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_reply(out_tdata, out_tuser[0], out_tuser[2:1]);
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_replies) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_replies = 0;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Called just after a rising edge; returns just after the edge that takes the beat.
  task automatic send_request(qmls_pkg::mode_t mode, index_t idx, rank_t rank);
    bit taken;
    if (!quiet && !no_gaps && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, rank, idx};
    in_tuser  <= mode;
    do begin
      @(negedge clk);
      taken = in_tvalid && in_tready;
      @(posedge clk);
    end while (!taken);
    board.note_request(mode, idx, rank);
  endtask

  // The count is changed only with the block idle and every reply delivered.
  task automatic write_count(count_t value);
    bit taken;
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      taken = cfg_valid && cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    board.count = value;
  endtask

  task automatic send_random();
    int pick;
    int span;
    index_t idx;
    rank_t  rank;
    pick = $urandom_range(0, 99);
    span = (board.count >= 1 && board.count < 8) ? int'(board.count) : 8;
    idx  = index_t'($urandom_range(0, span - 1));
    rank = ($urandom_range(0, 99) < 80) ? rank_t'($urandom_range(0, 15))
                                         : rank_t'($urandom_range(0, 255));
    if (pick < 35) begin
      send_request(qmls_pkg::MODE_LOCK, idx, rank);
    end else if (pick < 50) begin
      send_request(qmls_pkg::MODE_TRYLOCK, idx, rank);
    end else if (pick < 80) begin
      // Mostly a release by the current owner, which hands the mutex down the queue.
      if (board.held[idx]) rank = board.owner[idx];
      send_request(qmls_pkg::MODE_UNLOCK, idx, rank);
    end else if (pick < 88) begin
      send_request(qmls_pkg::MODE_UNLOCK, idx, rank);
    end else if (pick < 94) begin
      send_request(qmls_pkg::MODE_INVALID, index_t'($urandom_range(0, 63)),
                   rank_t'($urandom_range(0, 255)));
    end else begin
      send_request(qmls_pkg::mode_t'($urandom_range(0, 2)),
                   index_t'($urandom_range(0, 63)), rank_t'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(count_t count, int items);
    write_count(count);
    repeat (items) send_random();
  endtask

  initial begin
    board = new();
    cycles = 0;
    quiet = 0;
    no_gaps = 0;
    hold_replies = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hand-over, refusal, foreign unlock and release with an empty queue.
    send_request(qmls_pkg::MODE_LOCK, 0, 0);
    send_request(qmls_pkg::MODE_LOCK, 0, 255);
    send_request(qmls_pkg::MODE_TRYLOCK, 0, 1);
    send_request(qmls_pkg::MODE_UNLOCK, 0, 1);
    send_request(qmls_pkg::MODE_UNLOCK, 0, 0);
    send_request(qmls_pkg::MODE_UNLOCK, 0, 255);
    send_request(qmls_pkg::MODE_UNLOCK, 5, 3);
    send_request(qmls_pkg::MODE_TRYLOCK, 63, 200);
    send_request(qmls_pkg::MODE_INVALID, 63, 255);
    // The owner locking again is queued behind itself.
    send_request(qmls_pkg::MODE_LOCK, 1, 7);
    send_request(qmls_pkg::MODE_LOCK, 1, 7);
    send_request(qmls_pkg::MODE_UNLOCK, 1, 7);
    send_request(qmls_pkg::MODE_UNLOCK, 1, 7);
    // One rank waiting on two mutexes shares its link entry.
    send_request(qmls_pkg::MODE_LOCK, 2, 10);
    send_request(qmls_pkg::MODE_LOCK, 3, 11);
    send_request(qmls_pkg::MODE_LOCK, 2, 20);
    send_request(qmls_pkg::MODE_LOCK, 3, 20);
    send_request(qmls_pkg::MODE_LOCK, 2, 21);
    send_request(qmls_pkg::MODE_UNLOCK, 2, 10);
    send_request(qmls_pkg::MODE_UNLOCK, 3, 11);
    send_request(qmls_pkg::MODE_UNLOCK, 2, 20);
    send_request(qmls_pkg::MODE_UNLOCK, 3, 20);
    write_count(1);
    send_request(qmls_pkg::MODE_TRYLOCK, 0, 42);
    send_request(qmls_pkg::MODE_LOCK, 1, 42);
    write_count(0);
    send_request(qmls_pkg::MODE_TRYLOCK, 0, 43);
    write_count(127);
    send_request(qmls_pkg::MODE_UNLOCK, 63, 200);

    run_phase(64, 200);
    run_phase(8, 150);
    run_phase(1, 60);
    run_phase(127, 150);
    run_phase(0, 20);
    run_phase(count_t'($urandom_range(2, 63)), 120);

    // Long receiver hold-off while requests keep coming back to back.
    write_count(64);
    no_gaps = 1;
    hold_replies = 1;
    repeat (40) send_random();
    no_gaps = 0;

    quiet = 1;
    repeat (80) send_random();

    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("queued_mutex_lock_server_test OK");
    end else begin
      $display("queued_mutex_lock_server_test NOT OK");
    end
    $finish;
  end

endmodule
